// ----- src/sm4_pkg.sv -----
// SM4 package: S-box, FK and CK constants, round transforms and shared types.
// No dependencies; used by sm4_key_sched, sm4_round and sm4_block_cipher_unit.
`timescale 1ns / 1ps
package sm4_pkg;

    localparam int NumRounds  = 32;
    localparam int RoundBits  = 5;
    localparam int NumKeyRegs = 4;
    localparam int IdxBits    = 2;

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    // Register indexes of the key words.
    localparam logic [IdxBits-1:0] REG_KEY_WORD0 = 2'd0;
    localparam logic [IdxBits-1:0] REG_KEY_WORD1 = 2'd1;
    localparam logic [IdxBits-1:0] REG_KEY_WORD2 = 2'd2;
    localparam logic [IdxBits-1:0] REG_KEY_WORD3 = 2'd3;

    typedef enum logic [1:0] {
        KS_IDLE,
        KS_EXPAND,
        KS_RUN
    } ks_state_t;

    typedef struct packed {
        logic        valid;
        logic        mode;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
    } blk_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [0:255];
        t = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
        return t[a];
    endfunction

    function automatic logic [31:0] tau(input logic [31:0] v);
        return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Byte j of CK[i] is (4i+j)*7 modulo 256.
    function automatic logic [31:0] ck_word(input logic [RoundBits-1:0] i);
        logic [7:0] b;
        logic [7:0] base;
        logic [31:0] w;
        base = {1'b0, i, 2'b00};
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            b = (base + 8'(j)) * 8'd7;
            w = {w[23:0], b};
        end
        return w;
    endfunction

    function automatic logic [31:0] l_data(input logic [31:0] b);
        return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
    endfunction

    function automatic logic [31:0] l_key(input logic [31:0] b);
        return b ^ rotl(b, 13) ^ rotl(b, 23);
    endfunction

endpackage

// ----- src/sm4_if.sv -----
// Valid/ready channel interfaces for SM4 blocks, results and key writes.
// Depends on nothing.
`timescale 1ns / 1ps
interface sm4_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
    modport source (output valid, mode, in_word0, in_word1, in_word2, in_word3, input ready);
    modport sink (input valid, mode, in_word0, in_word1, in_word2, in_word3, output ready);
endinterface

interface sm4_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
    modport source (output valid, out_word0, out_word1, out_word2, out_word3, input ready);
    modport sink (input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface

interface sm4_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/sm4_key_sched.sv -----
// SM4 key schedule: key registers, one expansion round per cycle, round-key store.
// Depends on sm4_pkg.
`timescale 1ns / 1ps
module sm4_key_sched (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [sm4_pkg::IdxBits-1:0]  cfg_idx,
    input  logic [31:0]                  cfg_data,
    input  logic                         start,
    output logic                         ready,
    input  logic [sm4_pkg::RoundBits-1:0] rd_addr [0:sm4_pkg::NumRounds-1],
    output logic [31:0]                  rd_key [0:sm4_pkg::NumRounds-1]
);

    logic [31:0] key_reg [0:sm4_pkg::NumKeyRegs-1];
    logic [31:0] k_reg [0:3];
    logic [31:0] rk_reg [0:sm4_pkg::NumRounds-1];
    logic [sm4_pkg::RoundBits-1:0] cnt_reg;
    sm4_pkg::ks_state_t state_reg, state_next;
    logic [31:0] nk;

    // One key-schedule round.
    assign nk = k_reg[0] ^ sm4_pkg::l_key(sm4_pkg::tau(k_reg[1] ^ k_reg[2] ^ k_reg[3]
                ^ sm4_pkg::ck_word(cnt_reg)));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sm4_pkg::KS_IDLE:   if (start) state_next = sm4_pkg::KS_EXPAND;
            sm4_pkg::KS_EXPAND: if (cnt_reg == 5'(sm4_pkg::NumRounds - 1))
                                    state_next = sm4_pkg::KS_RUN;
            sm4_pkg::KS_RUN:    state_next = sm4_pkg::KS_RUN;
            default:            state_next = sm4_pkg::KS_IDLE;
        endcase
        if (cfg_we) state_next = sm4_pkg::KS_IDLE;
    end

    // Outputs.
    always_comb
    begin
        ready = (state_reg == sm4_pkg::KS_RUN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sm4_pkg::KS_IDLE;
            cnt_reg   <= '0;
            for (int i = 0; i < sm4_pkg::NumKeyRegs; i++) key_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) key_reg[cfg_idx] <= cfg_data;
            if (state_reg == sm4_pkg::KS_IDLE) cnt_reg <= '0;
            else if (state_reg == sm4_pkg::KS_EXPAND) cnt_reg <= cnt_reg + 5'd1;
        end
    end

    // Working key words and the round-key store.
    always_ff @(posedge clk)
    begin
        if (state_reg == sm4_pkg::KS_IDLE)
        begin
            k_reg[0] <= key_reg[0] ^ sm4_pkg::FK0;
            k_reg[1] <= key_reg[1] ^ sm4_pkg::FK1;
            k_reg[2] <= key_reg[2] ^ sm4_pkg::FK2;
            k_reg[3] <= key_reg[3] ^ sm4_pkg::FK3;
        end
        else if (state_reg == sm4_pkg::KS_EXPAND)
        begin
            k_reg[0] <= k_reg[1];
            k_reg[1] <= k_reg[2];
            k_reg[2] <= k_reg[3];
            k_reg[3] <= nk;
            rk_reg[cnt_reg] <= nk;
        end
    end

    // Each round stage reads its own key.
    always_comb
    begin
        for (int i = 0; i < sm4_pkg::NumRounds; i++) rd_key[i] = rk_reg[rd_addr[i]];
    end

endmodule

// ----- src/sm4_round.sv -----
// One SM4 data round as a pipeline stage with its own valid bit and stall.
// Depends on sm4_pkg.
`timescale 1ns / 1ps
module sm4_round (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  sm4_pkg::blk_t  d,
    input  logic [31:0]    rk,
    output sm4_pkg::blk_t  q
);

    sm4_pkg::blk_t blk_next;
    logic          valid_reg;
    logic          mode_reg;
    logic [31:0]   x0_reg;
    logic [31:0]   x1_reg;
    logic [31:0]   x2_reg;
    logic [31:0]   x3_reg;

    // Round function: shift the words, new word from tau and L.
    always_comb
    begin
        blk_next.valid = d.valid;
        blk_next.mode  = d.mode;
        blk_next.x0    = d.x1;
        blk_next.x1    = d.x2;
        blk_next.x2    = d.x3;
        blk_next.x3    = d.x0 ^ sm4_pkg::l_data(sm4_pkg::tau(d.x1 ^ d.x2 ^ d.x3 ^ rk));
    end

    // The valid bit is the only part of the stage that is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (advance) valid_reg <= blk_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_reg <= blk_next.mode;
            x0_reg   <= blk_next.x0;
            x1_reg   <= blk_next.x1;
            x2_reg   <= blk_next.x2;
            x3_reg   <= blk_next.x3;
        end
    end

    // Stage output.
    always_comb
    begin
        q.valid = valid_reg;
        q.mode  = mode_reg;
        q.x0    = x0_reg;
        q.x1    = x1_reg;
        q.x2    = x2_reg;
        q.x3    = x3_reg;
    end

endmodule

// ----- src/sm4_block_cipher_unit.sv -----
// Top level of the SM4 block cipher: key schedule, 32-stage round pipeline, ports.
// Depends on sm4_pkg, sm4_if, sm4_key_sched and sm4_round.
`timescale 1ns / 1ps
// SM4 cipher with a fully unrolled pipeline of 32 round stages, one round per
// stage. After reset or any key write, the first block waits while the key
// schedule computes one round key per cycle; after that a block enters every
// cycle unless the output stalls, and its result appears at the last stage. A
// stall on the output holds the whole pipeline. Key writes must be made only
// while no block is in flight.
module sm4_block_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    sm4_cfg_if.sink     cfg,
    sm4_in_if.sink      in_ch,
    sm4_out_if.source   out_ch
);

    logic keys_ok;
    logic advance;
    logic cfg_we;
    logic [sm4_pkg::RoundBits-1:0] rd_addr [0:sm4_pkg::NumRounds-1];
    logic [31:0] rd_key [0:sm4_pkg::NumRounds-1];
    sm4_pkg::blk_t stage [0:sm4_pkg::NumRounds];

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    sm4_key_sched u_ks (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg.index),
        .cfg_data (cfg.data),
        .start    (in_ch.valid),
        .ready    (keys_ok),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key)
    );

    // The pipeline moves when the last stage is empty or being taken.
    assign advance     = !stage[sm4_pkg::NumRounds].valid || out_ch.ready;
    assign in_ch.ready = advance && keys_ok;

    always_comb
    begin
        stage[0].valid = in_ch.valid && keys_ok;
        stage[0].mode  = in_ch.mode;
        stage[0].x0    = in_ch.in_word0;
        stage[0].x1    = in_ch.in_word1;
        stage[0].x2    = in_ch.in_word2;
        stage[0].x3    = in_ch.in_word3;
    end

    // Round stages; decrypt reads the keys in reverse order.
    for (genvar g = 0; g < sm4_pkg::NumRounds; g++)
    begin : g_round
        assign rd_addr[g] = stage[g].mode ? ~5'(g) : 5'(g);
        sm4_round u_round (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .d       (stage[g]),
            .rk      (rd_key[g]),
            .q       (stage[g+1])
        );
    end

    // Result words in reversed order.
    assign out_ch.valid     = stage[sm4_pkg::NumRounds].valid;
    assign out_ch.out_word0 = stage[sm4_pkg::NumRounds].x3;
    assign out_ch.out_word1 = stage[sm4_pkg::NumRounds].x2;
    assign out_ch.out_word2 = stage[sm4_pkg::NumRounds].x1;
    assign out_ch.out_word3 = stage[sm4_pkg::NumRounds].x0;

endmodule
